>>> rtl/button_edge_and_quadrature_events_defines.svh
// Assertion macros for the button and encoder event RTL.
`ifndef BUTTON_EDGE_AND_QUADRATURE_EVENTS_DEFINES_SVH
`define BUTTON_EDGE_AND_QUADRATURE_EVENTS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BQE_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BQE_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bqe_pkg.sv
// Types, codes and tables shared by the button and encoder event block.
package bqe_pkg;

   // Configuration register indexes
   localparam logic REG_DEBOUNCE_MS      = 1'b0;
   localparam logic REG_STEPS_PER_DETENT = 1'b1;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [2:0]  DETENT_RESET   = 3'd4;

   // Event codes
   localparam logic [2:0] EV_TOP    = 3'd0;
   localparam logic [2:0] EV_MIDDLE = 3'd1;
   localparam logic [2:0] EV_BOTTOM = 3'd2;
   localparam logic [2:0] EV_INC    = 3'd3;
   localparam logic [2:0] EV_DEC    = 3'd4;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        top_level;
      logic        middle_level;
      logic        bottom_level;
      logic [1:0]  encoder_phase;
   } req_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic       last_event;
   } rsp_type;

   // One evaluated sample handed to the serialiser
   typedef struct packed {
      logic       valid;
      logic [3:0] mask;
      logic       dir_up;
   } batch_type;

   // Quadrature step for index {previous phase, current phase}
   function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
      logic signed [1:0] s;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
         default: s = 2'sd0;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/bqe_eval.sv
// Input register, configuration, button and encoder state, event evaluation.
module bqe_eval (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bqe_pkg::req_type req_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   input  logic             can_load,
   output bqe_pkg::batch_type batch
);
   import bqe_pkg::*;

   logic             in_valid_ff;
   req_type          in_data_ff;
   logic [15:0]      debounce_ff;
   logic [2:0]       detent_ff;
   logic [2:0]       prev_level_ff;
   logic [31:0]      press_time_ff [3];
   logic [1:0]       prev_phase_ff;
   logic signed [3:0] step_ff;

   logic [2:0]       level;
   logic [2:0]       press;
   logic             eval_en;
   logic             phase_changed;
   logic signed [3:0] step_sum;
   logic signed [3:0] step_in;
   logic [3:0]       step_mag;
   logic [3:0]       thr;
   logic             enc_hit;

   assign req_ready = !in_valid_ff || can_load;
   assign eval_en   = in_valid_ff && can_load;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         detent_ff   <= DETENT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DEBOUNCE_MS:      debounce_ff <= csr_wdata;
            REG_STEPS_PER_DETENT: detent_ff   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Button presses: rising level and wrapped elapsed time over debounce
   assign level = {in_data_ff.bottom_level, in_data_ff.middle_level, in_data_ff.top_level};
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         press[i] = level[i] && !prev_level_ff[i] &&
                    ((in_data_ff.now_ms - press_time_ff[i]) > {16'd0, debounce_ff});
      end
   end

   // Encoder step accumulation and detent check
   assign phase_changed = in_data_ff.encoder_phase != prev_phase_ff;
   assign step_sum = step_ff + 4'(quad_step({prev_phase_ff, in_data_ff.encoder_phase}));
   assign step_mag = step_sum[3] ? 4'(-step_sum) : 4'(step_sum);
   assign thr      = (detent_ff == 3'd0) ? 4'd1 : {1'b0, detent_ff};
   assign enc_hit  = phase_changed && (step_mag >= thr);
   assign step_in  = enc_hit ? 4'sd0 : step_sum;

   // State update once the sample is evaluated
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= '0;
         prev_phase_ff <= '0;
         step_ff       <= '0;
         for (int i = 0; i < 3; i++) begin
            press_time_ff[i] <= '0;
         end
      end else if (eval_en) begin
         prev_level_ff <= level;
         for (int i = 0; i < 3; i++) begin
            if (press[i]) begin
               press_time_ff[i] <= in_data_ff.now_ms;
            end
         end
         if (phase_changed) begin
            prev_phase_ff <= in_data_ff.encoder_phase;
            step_ff       <= step_in;
         end
      end
   end

   always_comb begin
      batch.valid  = eval_en;
      batch.mask   = {enc_hit, press};
      batch.dir_up = !step_sum[3] && (step_sum != 4'sd0);
   end

endmodule

>>> rtl/bqe_serial.sv
// Result register: sends one sample's events one beat at a time.
`include "button_edge_and_quadrature_events_defines.svh"
module bqe_serial (
   input  logic               clock,
   input  logic               reset,
   input  bqe_pkg::batch_type batch,
   output logic               can_load,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bqe_pkg::rsp_type   rsp_data
);
   import bqe_pkg::*;

   logic [3:0] mask_ff;
   logic [3:0] mask_in;
   logic       dir_up_ff;
   logic [3:0] low;
   logic [3:0] rest;
   logic [3:0] popped;
   logic       fire;

   // Lowest pending event goes first
   assign low       = mask_ff & (~mask_ff + 4'd1);
   assign rest      = mask_ff & ~low;
   assign rsp_valid = |mask_ff;
   assign fire      = rsp_valid && rsp_ready;
   assign popped    = fire ? rest : mask_ff;
   assign can_load  = popped == 4'd0;
   assign mask_in   = can_load ? (batch.valid ? batch.mask : 4'd0) : popped;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      if (can_load && batch.valid) begin
         dir_up_ff <= batch.dir_up;
      end
   end

   // Event code of the beat on offer
   always_comb begin
      case (low)
         4'b0001: rsp_data.event_code = EV_TOP;
         4'b0010: rsp_data.event_code = EV_MIDDLE;
         4'b0100: rsp_data.event_code = EV_BOTTOM;
         4'b1000: rsp_data.event_code = dir_up_ff ? EV_INC : EV_DEC;
         default: rsp_data.event_code = EV_TOP;
      endcase
      rsp_data.last_event = rest == 4'd0;
   end

   `BQE_CHECK(a_last_single, rsp_valid && rsp_data.last_event, $onehot(mask_ff), "last beat with more pending")
   `BQE_CHECK_NEXT(a_stall_hold, rsp_valid && !rsp_ready, $stable(mask_ff), "pending events lost on stall")
   `BQE_CHECK_NEXT(a_load_shows, batch.valid && can_load && (batch.mask != 4'd0), rsp_valid, "loaded events not offered")
   `BQE_CHECK(a_no_overwrite, batch.valid, can_load && (popped == 4'd0), "sample loaded over pending events")

endmodule

>>> rtl/button_edge_and_quadrature_events.sv
// Top level of the button press and quadrature encoder event block.
//
//   channel  direction  payload                 handshake
//   req_     in         bqe_pkg::req_type       req_valid / req_ready
//   rsp_     out        bqe_pkg::rsp_type       rsp_valid / rsp_ready
//   csr_     in         index 1b, data 16b      csr_wr_en, no wait
//
// A sample is registered, evaluated combinationally, and its events leave one per beat.
// A sample carries up to four events: one per button and one for the encoder.
// A held sample moves on in the cycle the last event of the one before is accepted.
// Reset clears the button, encoder and handshake state and loads the register defaults.
// A stalled rsp_ holds the pending events; req_ready drops once the input register fills.
module button_edge_and_quadrature_events (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bqe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bqe_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);
   import bqe_pkg::*;

   batch_type batch;
   logic      can_load;

   bqe_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .can_load  (can_load),
      .batch     (batch)
   );

   bqe_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
